### rtl/chbd_pkg.sv
// Shared types, constants and helpers for the HTTP chunked body decoder.
// Depends on nothing; used by chbd_step, http_chunked_body_decoder and the testbench.
`timescale 1ns / 1ps

package chbd_pkg;

    localparam int SIZE_BITS_DEF = 32;
    localparam int PHASE_W       = 3;
    localparam int BYTE_W        = 8;

    // Parse phase codes.
    localparam logic [PHASE_W-1:0] PH_SIZE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_EXT     = 3'd1;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PEND    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_TRAILER = 3'd4;
    localparam logic [PHASE_W-1:0] PH_THDR    = 3'd5;
    localparam logic [PHASE_W-1:0] PH_FINAL   = 3'd6;

    localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;

    typedef struct packed {
        logic              payload_valid;
        logic [BYTE_W-1:0] out_byte;
        logic              complete;
    } res_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_t;

    // Decodes one ASCII hex digit in either case.
    function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
        hex_t h;
        h.is_hex = 1'b0;
        h.value  = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            h.is_hex = 1'b1;
            h.value  = c[3:0];
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            h.is_hex = 1'b1;
            h.value  = c[3:0] + 4'd9;
        end
        return h;
    endfunction

endpackage

### rtl/http_chunked_body_decoder.sv
// HTTP chunked body decoder: one raw body byte in, one result out per transaction.
// An accepted byte's result is held in the output register from the next cycle on.
// Throughput: one byte per cycle while downstream does not stall, set by the combinational
// parse step and the output register, which takes a new byte in the cycle its result is taken.
// Reset (rst_n low, asynchronous): size phase, count zero, output register empty.
// Depends on chbd_pkg and chbd_step.
`timescale 1ns / 1ps

module http_chunked_body_decoder #(
    parameter int SIZE_BITS = chbd_pkg::SIZE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [chbd_pkg::BYTE_W-1:0] in_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        payload_valid,
    output logic [chbd_pkg::BYTE_W-1:0] out_byte,
    output logic                        complete
);
    import chbd_pkg::*;

    logic [PHASE_W-1:0]   phase_reg;
    logic [PHASE_W-1:0]   phase_next;
    logic [SIZE_BITS-1:0] count_reg;
    logic [SIZE_BITS-1:0] count_next;
    logic                 out_valid_reg;
    res_t                 res_reg;
    res_t                 res_next;
    logic                 accept;

    chbd_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .in_byte    (in_byte),
        .phase      (phase_reg),
        .count      (count_reg),
        .phase_next (phase_next),
        .count_next (count_next),
        .res        (res_next)
    );

    // A held result blocks the input only while downstream stalls it.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIZE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign out_valid     = out_valid_reg;
    assign payload_valid = res_reg.payload_valid;
    assign out_byte      = res_reg.out_byte;
    assign complete      = res_reg.complete;

    a_no_payload_when_complete: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(payload_valid && complete))
        else $error("payload byte reported after completion");

    a_complete_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && complete |=> !out_valid || complete)
        else $error("complete dropped after being set");

    a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !payload_valid |-> out_byte == '0)
        else $error("non-payload result carries a nonzero byte");

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with an empty output register");

endmodule

### rtl/chbd_step.sv
// Next-state and result logic for one body byte of the chunked decoder.
// Depends on chbd_pkg.
`timescale 1ns / 1ps

module chbd_step #(
    parameter int SIZE_BITS = chbd_pkg::SIZE_BITS_DEF
) (
    input  logic [chbd_pkg::BYTE_W-1:0]  in_byte,
    input  logic [chbd_pkg::PHASE_W-1:0] phase,
    input  logic [SIZE_BITS-1:0]         count,
    output logic [chbd_pkg::PHASE_W-1:0] phase_next,
    output logic [SIZE_BITS-1:0]         count_next,
    output chbd_pkg::res_t               res
);
    import chbd_pkg::*;

    hex_t                 hex;
    logic [SIZE_BITS-1:0] count_shift;
    logic [SIZE_BITS-1:0] count_dec;
    logic [PHASE_W-1:0]   size_end_phase;
    logic                 is_lf;

    assign hex         = hex_decode(in_byte);
    assign count_shift = {count[SIZE_BITS-5:0], hex.value};
    assign count_dec   = count - {{(SIZE_BITS-1){1'b0}}, 1'b1};
    assign is_lf       = (in_byte == CH_LF);
    // A size line that ends with a zero count starts the trailer.
    assign size_end_phase = (count == '0) ? PH_TRAILER : PH_PAYLOAD;

    always_comb
    begin
        phase_next        = phase;
        count_next        = count;
        res.payload_valid = 1'b0;
        res.out_byte      = '0;
        case (phase)
            PH_SIZE:
            begin
                if (hex.is_hex)
                    count_next = count_shift;
                else if (in_byte == CH_SEMI)
                    phase_next = PH_EXT;
                else if (is_lf)
                    phase_next = size_end_phase;
            end
            PH_EXT:
            begin
                if (is_lf)
                    phase_next = size_end_phase;
            end
            PH_PAYLOAD:
            begin
                res.payload_valid = 1'b1;
                res.out_byte      = in_byte;
                count_next        = count_dec;
                if (count_dec == '0)
                    phase_next = PH_PEND;
            end
            PH_PEND:
            begin
                if (is_lf)
                    phase_next = PH_SIZE;
            end
            PH_TRAILER:
            begin
                if (is_lf)
                    phase_next = PH_FINAL;
                else if (in_byte != CH_CR)
                    phase_next = PH_THDR;
            end
            PH_THDR:
            begin
                if (is_lf)
                    phase_next = PH_TRAILER;
            end
            default:
            begin
                phase_next = phase;
            end
        endcase
        res.complete = (phase_next == PH_FINAL);
    end

endmodule

### test/http_chunked_body_decoder_test.sv
// Self-checking testbench for http_chunked_body_decoder: feeds one long chunked body
// byte by byte and checks every result against a cycle-free decoder kept in step.
// Depends on chbd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module http_chunked_body_decoder_test;

    import chbd_pkg::*;

    localparam int SIZE_W      = SIZE_BITS_DEF;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int HOLD_AFTER  = 300;
    localparam int SHOW_MAX    = 10;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              in_valid      = 1'b0;
    logic [BYTE_W-1:0] in_byte       = '0;
    logic              rx_pause      = 1'b0;
    int                hold_left     = 0;
    logic              hold_done     = 1'b0;
    wire               out_stall     = rx_pause | (hold_left != 0);
    logic              in_stall;
    logic              out_valid;
    logic              payload_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              complete;

    logic [BYTE_W-1:0] body_bytes[$];
    res_t              predicted_out[$];

    logic [PHASE_W-1:0] dec_phase = PH_SIZE;
    logic [SIZE_W-1:0]  dec_count = '0;

    int accepted_count = 0;
    int results_count  = 0;
    int mismatch_count = 0;
    int idle_cycles    = 0;
    int body_total     = 0;
    int gap_left       = 0;
    int pause_left     = 0;

    http_chunked_body_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_valid (payload_valid),
        .out_byte      (out_byte),
        .complete      (complete)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic bit is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39)
            v = c - 8'h30;
        else if (c <= 8'h46)
            v = c - 8'h37;
        else
            v = c - 8'h57;
        return v[3:0];
    endfunction

    // Advances the decoder state by one body byte and gives the result it produces.
    function automatic res_t chunk_decode(input logic [7:0] c);
        res_t r;
        r.payload_valid = 1'b0;
        r.out_byte      = '0;
        case (dec_phase)
            PH_SIZE:
            begin
                if (is_hex(c))
                    dec_count = {dec_count[SIZE_W-5:0], hex_nibble(c)};
                else if (c == CH_SEMI)
                    dec_phase = PH_EXT;
                else if (c == CH_LF)
                    dec_phase = (dec_count == '0) ? PH_TRAILER : PH_PAYLOAD;
            end
            PH_EXT:
            begin
                if (c == CH_LF)
                    dec_phase = (dec_count == '0) ? PH_TRAILER : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                r.payload_valid = 1'b1;
                r.out_byte      = c;
                dec_count       = dec_count - {{(SIZE_W-1){1'b0}}, 1'b1};
                if (dec_count == '0)
                    dec_phase = PH_PEND;
            end
            PH_PEND:
            begin
                if (c == CH_LF)
                    dec_phase = PH_SIZE;
            end
            PH_TRAILER:
            begin
                if (c == CH_LF)
                    dec_phase = PH_FINAL;
                else if (c != CH_CR)
                    dec_phase = PH_THDR;
            end
            PH_THDR:
            begin
                if (c == CH_LF)
                    dec_phase = PH_TRAILER;
            end
            default:
            begin
            end
        endcase
        r.complete = (dec_phase == PH_FINAL);
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] letter_base;
        letter_base = $urandom_range(0, 1) ? 8'h41 : 8'h61;
        if (v < 4'd10)
            return 8'h30 + {4'd0, v};
        return letter_base + {4'd0, v} - 8'd10;
    endfunction

    // A byte that a size line ignores: no hex digit, semicolon or line feed.
    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_hex(c) || c == CH_SEMI || c == CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] line_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_LF);
        return c;
    endfunction

    task automatic put_size(input int unsigned n, input bit pad);
        int digits;
        digits = 1;
        if (pad)
            digits = 8;
        else
            while (digits < 8 && (n >> (4 * digits)) != 0)
                digits++;
        for (int i = digits - 1; i >= 0; i--)
            body_bytes.push_back(hex_char(4'(n >> (4 * i))));
    endtask

    initial
    begin
        int unsigned size;
        int unsigned sel;
        logic [7:0]  c;

        // Noise before the size digit, payload zero, bare line feed after it.
        body_bytes.push_back(8'h67);
        body_bytes.push_back(8'h31);
        body_bytes.push_back(CH_CR);
        body_bytes.push_back(CH_LF);
        body_bytes.push_back(8'h00);
        body_bytes.push_back(CH_LF);
        // Extension holding hex digits and a second semicolon, all skipped.
        body_bytes.push_back(8'h32);
        body_bytes.push_back(CH_SEMI);
        body_bytes.push_back(8'h61);
        body_bytes.push_back(8'h42);
        body_bytes.push_back(CH_SEMI);
        body_bytes.push_back(CH_CR);
        body_bytes.push_back(CH_LF);
        // A line feed inside the payload is data; junk after the payload is skipped.
        body_bytes.push_back(8'hFF);
        body_bytes.push_back(CH_LF);
        body_bytes.push_back(8'h71);
        body_bytes.push_back(CH_LF);
        // Nine digits: the count wraps round to one.
        body_bytes.push_back(8'h31);
        put_size(1, 1'b1);
        body_bytes.push_back(CH_LF);
        body_bytes.push_back(8'h80);
        body_bytes.push_back(CH_CR);
        body_bytes.push_back(CH_LF);

        while (body_bytes.size() < 1320)
        begin
            sel  = $urandom_range(0, 19);
            size = (sel < 14) ? $urandom_range(1, 8) :
                   (sel < 19) ? $urandom_range(9, 40) : $urandom_range(41, 160);
            if ($urandom_range(0, 3) == 0)
                body_bytes.push_back(8'h30);
            if ($urandom_range(0, 7) == 0)
            begin
                // Extra leading digits are shifted out by the wrap.
                repeat ($urandom_range(1, 4))
                    body_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
                put_size(size, 1'b1);
            end
            else
                put_size(size, 1'b0);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    body_bytes.push_back(noise_char());
            if ($urandom_range(0, 4) == 0)
            begin
                body_bytes.push_back(CH_SEMI);
                repeat ($urandom_range(0, 6))
                    body_bytes.push_back(line_char());
            end
            if ($urandom_range(0, 3) != 0)
                body_bytes.push_back(CH_CR);
            body_bytes.push_back(CH_LF);
            repeat (size)
                body_bytes.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 3))
                    body_bytes.push_back(line_char());
            else if ($urandom_range(0, 3) != 0)
                body_bytes.push_back(CH_CR);
            body_bytes.push_back(CH_LF);
        end

        // Last chunk: a size that wraps to zero, with an extension.
        body_bytes.push_back(8'h31);
        put_size(0, 1'b1);
        body_bytes.push_back(CH_SEMI);
        body_bytes.push_back(8'h65);
        body_bytes.push_back(CH_CR);
        body_bytes.push_back(CH_LF);
        // Trailer header lines, some behind a stray carriage return.
        repeat ($urandom_range(2, 4))
        begin
            if ($urandom_range(0, 1))
                body_bytes.push_back(CH_CR);
            do
                c = line_char();
            while (c == CH_CR);
            body_bytes.push_back(c);
            repeat ($urandom_range(0, 12))
                body_bytes.push_back(line_char());
            body_bytes.push_back(CH_CR);
            body_bytes.push_back(CH_LF);
        end
        body_bytes.push_back(CH_CR);
        body_bytes.push_back(CH_LF);
        // Everything after the blank line must be ignored.
        repeat (40)
            body_bytes.push_back(8'($urandom_range(0, 255)));

        body_total = body_bytes.size();
        wait (accepted_count == body_total && results_count == body_total);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && predicted_out.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Sender: a random gap before each byte, none at all in every other block of 128.
    always @(posedge clk or negedge rst_n)
    begin
        int gap;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= '0;
            gap_left <= 0;
        end
        else if (in_valid && !in_stall)
        begin
            predicted_out.push_back(chunk_decode(in_byte));
            accepted_count <= accepted_count + 1;
            gap = accepted_count[7] ? 0 : $urandom_range(0, 7);
            if (gap == 0 && body_bytes.size() != 0)
            begin
                in_valid <= 1'b1;
                in_byte  <= body_bytes.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
                gap_left <= (gap > 0) ? gap - 1 : 0;
            end
        end
        else if (!in_valid)
        begin
            if (gap_left != 0)
                gap_left <= gap_left - 1;
            else if (body_bytes.size() != 0)
            begin
                in_valid <= 1'b1;
                in_byte  <= body_bytes.pop_front();
            end
        end
    end

    // Receiver: checks each transaction and draws a short stall after it.
    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        int   n;
        if (!rst_n)
        begin
            rx_pause   <= 1'b0;
            pause_left <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            got = '{payload_valid, out_byte, complete};
            if (predicted_out.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= SHOW_MAX)
                    $display("unexpected result: valid=%0b byte=%02h complete=%0b",
                             got.payload_valid, got.out_byte, got.complete);
            end
            else
            begin
                want = predicted_out.pop_front();
                if (got.payload_valid !== want.payload_valid ||
                    got.out_byte !== want.out_byte || got.complete !== want.complete)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_MAX)
                        $display({"mismatch on result %0d: expected valid=%0b byte=%02h ",
                                  "complete=%0b, got valid=%0b byte=%02h complete=%0b"},
                                 results_count, want.payload_valid, want.out_byte,
                                 want.complete, got.payload_valid, got.out_byte,
                                 got.complete);
                end
            end
            results_count <= results_count + 1;
            n = results_count[6] ? 0 : $urandom_range(0, 7);
            pause_left <= n;
            rx_pause   <= (n != 0);
        end
        else if (pause_left != 0)
        begin
            pause_left <= pause_left - 1;
            rx_pause   <= (pause_left > 1);
        end
    end

    // One long hold-off on the output so that the decoder backs up into its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_count >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule

### sim.f
rtl/chbd_pkg.sv
rtl/chbd_step.sv
rtl/http_chunked_body_decoder.sv
test/http_chunked_body_decoder_test.sv
